### hdl/region_mean_brightness_normalizer_unit_macros.svh
// ----------------------------------------------------------------------------
// region mean brightness normalizer - assertion macros
// shared concurrent assertion shorthands, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef REGION_MEAN_BRIGHTNESS_NORMALIZER_UNIT_MACROS_SVH
`define REGION_MEAN_BRIGHTNESS_NORMALIZER_UNIT_MACROS_SVH

// same-cycle implication
`define RMBN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMBN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rmbn_pkg.sv
// ----------------------------------------------------------------------------
// rmbn_pkg
// types, codes and constants of the region mean brightness normalizer
// ----------------------------------------------------------------------------
package rmbn_pkg;

    // field widths
    localparam int MODE_W  = 2;
    localparam int EDGE_W  = 9;
    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int PIX_W   = 8;
    localparam int SUM_W   = 28;
    localparam int CFG_W   = 10;
    localparam int CIDX_W  = 2;

    // rows representable by a row field
    localparam int ROW_SPAN = 2 ** ROW_W;

    // parameter defaults
    localparam int MAX_BAND_COLS_DEF = 512;
    localparam int MAX_ROWS_DEF      = 1024;

    // register reset values and the pixel maximum
    localparam logic [COL_W-1:0] FIRST_COL_RST = 10'd91;
    localparam logic [COL_W-1:0] COLS_RST      = 10'd400;
    localparam logic [PIX_W-1:0] TARGET_RST    = 8'd128;
    localparam logic [PIX_W-1:0] PIX_MAX       = 8'd255;

    // item modes
    localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CORRECT = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_FIRST_COL = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_COLS      = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TARGET    = 2'd2;

    // input word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [EDGE_W-1:0] edge_index;
        logic [ROW_W-1:0]  upper_row;
        logic [ROW_W-1:0]  lower_row;
        logic [ROW_W-1:0]  pixel_row;
        logic [COL_W-1:0]  pixel_col;
        logic [PIX_W-1:0]  pixel_value;
        logic              last;
    } t_in_item;

    // output word
    typedef struct packed {
        logic [PIX_W-1:0] adjusted_pixel;
        logic [PIX_W-1:0] region_mean;
        logic             out_last;
    } t_out_item;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MEAS = 4'b0010,
        S_CNT  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

endpackage

### hdl/region_mean_brightness_normalizer_unit.sv
// ----------------------------------------------------------------------------
// region mean brightness normalizer
// Input words on i_in_* (valid/ready) carry a mode: edge words load the
// top and bottom row of one band column into an on-chip table, measuring
// pixels add into a band sum, correcting pixels give one output word each
// on o_out_* (valid/ready). Registers are written on i_cfg_* while idle.
// Edge words are written to the table as taken. A measuring pixel reads
// the table as taken, then adds in S_MEAS; the last one adds a sweep over
// the table for the band count, then a bit-serial divider for the mean
// (skipped, mean zero, if the count is not positive). The single table
// read port sets the sweep length. A correcting pixel goes into the output
// register as taken; the next word is taken while a result waits, but a
// correcting word waits while the output register is full and not being
// taken. Reset clears sum, count, mean and registers to their defaults;
// the edge table is not cleared and must be loaded before measuring.
// ----------------------------------------------------------------------------
`include "region_mean_brightness_normalizer_unit_macros.svh"

module region_mean_brightness_normalizer_unit
    import rmbn_pkg::*;
#(
    parameter int MAX_BAND_COLS = MAX_BAND_COLS_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int IDX_W  = (MAX_BAND_COLS > 1) ? $clog2(MAX_BAND_COLS) : 1;
    localparam int AC_W   = $clog2(MAX_BAND_COLS + 1);
    localparam int CNT_W  = $clog2(MAX_BAND_COLS * ROW_SPAN + 1) + 1;
    localparam int DVS_W  = CNT_W - 1;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int TERM_W = ROW_W + 2;
    localparam logic [31:0] MBC_U  = 32'(MAX_BAND_COLS);
    localparam logic [31:0] ROWS_U = 32'(MAX_ROWS);

    // configuration registers
    logic [COL_W-1:0] r_first_col;
    logic [COL_W-1:0] r_cols;
    logic [PIX_W-1:0] r_target;

    // control and state
    t_state              r_state, n_state;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic signed [CNT_W-1:0] r_cnt, n_cnt;
    logic [PIX_W-1:0]    r_mean, n_mean;
    logic [AC_W-1:0]     r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [DVS_W-1:0]    r_div, n_div;
    logic [DVS_W-1:0]    r_rem, n_rem;
    logic [SUM_W-1:0]    r_quo, n_quo;
    logic [STEP_W-1:0]   r_step, n_step;

    // captured measuring pixel
    logic [ROW_W-1:0]    r_row;
    logic [PIX_W-1:0]    r_pix;
    logic                r_last;
    logic                r_col_ok;

    // output register
    t_out_item           r_out;
    logic                r_out_valid;

    // band table: top row in the upper half, bottom row in the lower half
    logic [2*ROW_W-1:0]  band_mem [MAX_BAND_COLS];
    logic [2*ROW_W-1:0]  r_band;

    logic                in_acc;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [IDX_W-1:0]    mem_raddr;
    logic [AC_W-1:0]     active;
    logic [COL_W-1:0]    off;
    logic                col_ok;
    logic [EDGE_W+IDX_W-1:0] eidx_ext;
    logic [COL_W+IDX_W-1:0]  off_ext;
    logic [ROW_W-1:0]    band_top;
    logic [ROW_W-1:0]    band_bot;
    logic                in_band;
    logic [SUM_W:0]      sum_add;
    logic signed [TERM_W-1:0] term;
    logic [DVS_W:0]      trial;
    logic                trial_ge;
    logic [SUM_W-1:0]    quo_next;
    logic signed [ROW_W-1:0] corr;
    t_out_item           out_next;

    // handshakes
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE)
                       && ((i_in_data.mode != MODE_CORRECT) || !r_out_valid || i_out_ready);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // band column count, saturated at the table depth
    assign active = ({22'd0, r_cols} > MBC_U) ? AC_W'(MAX_BAND_COLS) : AC_W'(r_cols);

    // band column of the incoming pixel
    assign off      = i_in_data.pixel_col - r_first_col;
    assign col_ok   = (i_in_data.pixel_col >= r_first_col) && ({22'd0, off} < 32'(active));
    assign off_ext  = (COL_W + IDX_W)'(off);
    assign eidx_ext = (EDGE_W + IDX_W)'(i_in_data.edge_index);

    // table port addresses
    assign mem_we    = in_acc && (i_in_data.mode == MODE_EDGE)
                     && ({23'd0, i_in_data.edge_index} < MBC_U);
    assign mem_waddr = eidx_ext[IDX_W-1:0];
    assign mem_raddr = (r_state == S_CNT) ? r_idx[IDX_W-1:0] : off_ext[IDX_W-1:0];

    // band test of the captured pixel
    assign band_top = r_band[2*ROW_W-1:ROW_W];
    assign band_bot = r_band[ROW_W-1:0];
    assign in_band  = r_col_ok && ({22'd0, r_row} < ROWS_U)
                    && (r_row >= band_top) && (r_row <= band_bot);
    assign sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(r_pix);

    // per-column count term: bottom - top + 1
    assign term = $signed({2'b00, band_bot}) - $signed({2'b00, band_top})
                + TERM_W'(1);

    // restoring division, one quotient bit per cycle
    assign trial    = {r_rem, r_quo[SUM_W-1]};
    assign trial_ge = trial >= {1'b0, r_div};
    assign quo_next = {r_quo[SUM_W-2:0], trial_ge};

    // correction and clamp
    assign corr = $signed({2'b00, i_in_data.pixel_value}) + $signed({2'b00, r_target})
                - $signed({2'b00, r_mean});
    always_comb begin
        out_next.region_mean = r_mean;
        out_next.out_last    = i_in_data.last;
        if (corr[ROW_W-1]) begin
            out_next.adjusted_pixel = '0;
        end else if (corr[PIX_W]) begin
            out_next.adjusted_pixel = PIX_MAX;
        end else begin
            out_next.adjusted_pixel = corr[PIX_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_mean  = r_mean;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_div   = r_div;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.mode == MODE_MEASURE)) begin
                    n_state = S_MEAS;
                end
            end
            S_MEAS: begin
                if (in_band) begin
                    n_sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                end
                if (r_last) begin
                    n_state = S_CNT;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_cnt   = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CNT: begin
                // issue one table read per cycle, add the one from last cycle
                n_pend = r_idx < active;
                if (r_idx < active) begin
                    n_idx = r_idx + AC_W'(1);
                end
                if (r_pend) begin
                    n_cnt = r_cnt + {{(CNT_W-TERM_W){term[TERM_W-1]}}, term};
                end
                if (!r_pend && (r_idx == active)) begin
                    n_sum = '0;
                    if (r_cnt[CNT_W-1] || (r_cnt == '0)) begin
                        n_mean  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_div   = r_cnt[DVS_W-1:0];
                        n_rem   = '0;
                        n_quo   = r_sum;
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem  = trial_ge ? DVS_W'(trial - {1'b0, r_div}) : trial[DVS_W-1:0];
                n_quo  = quo_next;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_mean  = (|quo_next[SUM_W-1:PIX_W]) ? PIX_MAX : quo_next[PIX_W-1:0];
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_mean  <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_mean  <= n_mean;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_step  <= n_step;
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    // capture of a measuring pixel
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row    <= i_in_data.pixel_row;
            r_pix    <= i_in_data.pixel_value;
            r_last   <= i_in_data.last;
            r_col_ok <= col_ok;
        end
    end

    // band table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            band_mem[mem_waddr] <= {i_in_data.upper_row, i_in_data.lower_row};
        end
        r_band <= band_mem[mem_raddr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && (i_in_data.mode == MODE_CORRECT)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.mode == MODE_CORRECT)) begin
            r_out <= out_next;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_col <= FIRST_COL_RST;
            r_cols      <= COLS_RST;
            r_target    <= TARGET_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FIRST_COL: r_first_col <= i_cfg_data;
                CFG_COLS:      r_cols      <= i_cfg_data;
                CFG_TARGET:    r_target    <= i_cfg_data[PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // checks
    `RMBN_ASSERT_NEXT(a_corr_gives_word, in_acc && (i_in_data.mode == MODE_CORRECT), o_out_valid, "correcting word gave no output word")
    `RMBN_ASSERT_NEXT(a_meas_reads_table, in_acc && (i_in_data.mode == MODE_MEASURE), r_state == S_MEAS, "measuring word did not reach the band test")
    `RMBN_ASSERT_NOW(a_sum_clear_in_div, r_state == S_DIV, r_sum == '0, "band sum not cleared during division")
    `RMBN_ASSERT_NOW(a_sweep_in_range, r_state == S_CNT, r_idx <= active, "count sweep ran past the band columns")

endmodule
